// ===== hdl/dcbm_pkg.sv =====
// Shared widths, register indexes and fixed-point layout for the DC-blocking
// filter and level meter. No dependencies; imported by every module of the block.
package dcbm_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b1;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLE_W = 16;
    localparam int POLE_W   = 16;
    localparam int GAIN_W   = 5;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 2 * ROOT_W;

    // Filter state y is signed Q25.16 in 42 bits.
    localparam int Y_W      = 42;
    localparam int FRAC_W   = 16;
    // The feedback product is formed from a low unsigned slice and a high signed slice.
    localparam int Y_SPLIT  = 26;

    // Shared multiplier: signed 17 x signed 32.
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [POLE_W-1:0] POLE_RESET = 16'd65208;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 5'd4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [ROOT_W-1:0]   level_t;

endpackage

// ===== hdl/dcbm_divsqrt.sv =====
// Iterative unit for the frame RMS: restoring division of the square sum by the
// sample count, then a digit-by-digit square root. Uses dcbm_pkg.
module dcbm_divsqrt #(
    parameter int SUM_W = 40,
    parameter int CNT_W = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_W-1:0]      dividend,
    input  logic [CNT_W-1:0]      divisor,
    output logic                  done,
    output dcbm_pkg::level_t      root
);
    import dcbm_pkg::*;

    localparam int DV_W     = (SUM_W > RAD_W) ? SUM_W : RAD_W;
    localparam int SQ_REM_W = ROOT_W + 4;
    localparam int SUB_W    = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
    localparam int ITER_W   = $clog2(DV_W);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_SQRT = 2'd2;

    logic [1:0]        phase_reg;
    logic              done_reg;
    logic [DV_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [SUB_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] iter_reg;

    logic [SUB_W-1:0]  trial;
    logic [SUB_W-1:0]  sub_b;
    logic [SUB_W:0]    diff;
    logic              ge;
    logic [SUB_W-1:0]  rem_next;

    // One subtractor serves both the division and the root steps.
    always_comb
    begin
        unique case (phase_reg)
            P_DIV:
            begin
                trial = {rem_reg[SUB_W-2:0], dvd_reg[DV_W-1]};
                sub_b = SUB_W'(dsr_reg);
            end
            P_SQRT:
            begin
                trial = {rem_reg[SUB_W-3:0], dvd_reg[RAD_W-1:RAD_W-2]};
                sub_b = SUB_W'({root_reg, 2'b01});
            end
            default:
            begin
                trial = '0;
                sub_b = '0;
            end
        endcase
        diff     = {1'b0, trial} - {1'b0, sub_b};
        ge       = ~diff[SUB_W];
        rem_next = ge ? diff[SUB_W-1:0] : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    if (iter_reg == '0)
                    begin
                        phase_reg <= P_SQRT;
                    end
                end
                P_SQRT:
                begin
                    if (iter_reg == '0)
                    begin
                        phase_reg <= P_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    dvd_reg  <= DV_W'(dividend);
                    dsr_reg  <= divisor;
                    rem_reg  <= '0;
                    iter_reg <= ITER_W'(DV_W - 1);
                end
            end
            P_DIV:
            begin
                // The dividend shifts out at the top while quotient bits shift in below.
                dvd_reg <= {dvd_reg[DV_W-2:0], ge};
                if (iter_reg == '0)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                    iter_reg <= ITER_W'(ROOT_W - 1);
                end
                else
                begin
                    rem_reg  <= rem_next;
                    iter_reg <= iter_reg - 1'b1;
                end
            end
            P_SQRT:
            begin
                dvd_reg  <= {dvd_reg[DV_W-3:0], 2'b00};
                rem_reg  <= rem_next;
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                iter_reg <= iter_reg - 1'b1;
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/dc_block_gain_rms_peak_meter_top.sv =====
// DC-blocking high-pass filter with gain, saturation and a per-frame RMS and peak meter.
// Depends on dcbm_pkg and dcbm_divsqrt.
//
// Usage: PCM words enter on the input channel (sample_in, last_in_frame) with
// in_valid/in_ready. Each accepted word gives exactly one output word (sample_out,
// frame_done, frame_rms, frame_peak) on out_valid/out_ready. frame_done marks the
// word that closes a frame, either by last_in_frame or because the frame has reached
// MAX_FRAME words; only then do frame_rms and frame_peak carry data, otherwise zero.
// The pole and gain registers are written through cfg_wr_en/cfg_index/cfg_data; the
// user must write them only while the block is idle, the block does not enforce it.
// Processing: a word runs through one shared 17x32 multiplier four times
// (two halves of the feedback product, gain, square); it is loaded into the output
// register in the same cycle as in_ready returns, and a new word is accepted only
// after the last one has been loaded there. A frame's last word also runs the
// iterative divider and square root, one bit or one digit a cycle.
// Reset clears the filter history, the frame statistics and the output valid flag and
// loads the default pole and gain; no sweep is needed afterwards. When the receiver
// stalls, the finished word waits in the output register while the next word is
// accepted and processed; that word then waits until the register frees.
module dc_block_gain_rms_peak_meter_top #(
    parameter int MAX_FRAME = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dcbm_pkg::sample_t                   sample_in,
    input  logic                                last_in_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dcbm_pkg::sample_t                   sample_out,
    output logic                                frame_done,
    output dcbm_pkg::level_t                    frame_rms,
    output dcbm_pkg::level_t                    frame_peak,
    input  logic                                cfg_wr_en,
    input  logic [dcbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dcbm_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = CNT_W + 2 * (SAMPLE_W - 1);
    localparam int SQ_W  = 2 * (SAMPLE_W - 1) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MLO  = 4'd1;
    localparam logic [3:0] S_MHI  = 4'd2;
    localparam logic [3:0] S_FILT = 4'd3;
    localparam logic [3:0] S_GAIN = 4'd4;
    localparam logic [3:0] S_SAT  = 4'd5;
    localparam logic [3:0] S_SQR  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_WAIT = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]               state_reg, state_next;
    logic [POLE_W-1:0]        pole_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [SAMPLE_W-1:0] xprev_reg;
    logic signed [Y_W-1:0]    yprev_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SAMPLE_W-1:0]      peak_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                     last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [Y_W-1:0]           lo_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [SAMPLE_W-1:0]      mag_reg;
    logic                     end_reg;
    logic [SAMPLE_W-1:0]      fpeak_reg;

    logic                     out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                     frame_done_reg;
    logic [ROOT_W-1:0]        frame_rms_reg;
    logic [ROOT_W-1:0]        frame_peak_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [57:0]       fb_full;
    logic signed [Y_W-1:0]    fb_shift;
    logic signed [SAMPLE_W:0] dx;
    logic signed [Y_W+1:0]    y_wide;
    logic signed [Y_W-1:0]    y_next;
    logic signed [MUL_B_W-1:0] y_clamp;
    logic signed [PROD_W-1:0] p_bias;
    logic signed [PROD_W-FRAC_W-1:0] t_int;
    logic signed [SAMPLE_W-1:0] s_next;
    logic [SAMPLE_W-1:0]      mag_next;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]         cnt_next;
    logic [SAMPLE_W-1:0]      peak_next;
    logic                     frame_end;
    logic                     out_free;
    logic                     ds_start;
    logic                     ds_done;
    logic [ROOT_W-1:0]        ds_root;

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            S_MLO:
            begin
                mul_a = $signed({1'b0, pole_reg});
                mul_b = $signed({{(MUL_B_W - Y_SPLIT){1'b0}}, yprev_reg[Y_SPLIT-1:0]});
            end
            S_MHI:
            begin
                mul_a = $signed({1'b0, pole_reg});
                mul_b = MUL_B_W'($signed(yprev_reg[Y_W-1:Y_SPLIT]));
            end
            S_GAIN:
            begin
                mul_a = $signed({{(MUL_A_W - GAIN_W){1'b0}}, gain_reg});
                mul_b = y_clamp;
            end
            S_SQR:
            begin
                mul_a = $signed({1'b0, mag_reg});
                mul_b = $signed({{(MUL_B_W - SAMPLE_W){1'b0}}, mag_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Filter update: R*y_prev rounded toward minus infinity, plus the input difference.
    always_comb
    begin
        fb_full  = $signed({prod_reg[MUL_B_W-1:0], {Y_SPLIT{1'b0}}})
                 + $signed({{(58 - Y_W){1'b0}}, lo_reg});
        fb_shift = fb_full[57:FRAC_W];
        dx       = $signed({x_reg[SAMPLE_W-1], x_reg}) - $signed({xprev_reg[SAMPLE_W-1], xprev_reg});
        y_wide   = $signed({{(Y_W + 2 - SAMPLE_W - 1 - FRAC_W){dx[SAMPLE_W]}}, dx, {FRAC_W{1'b0}}})
                 + $signed({{2{fb_shift[Y_W-1]}}, fb_shift});
        if (y_wide[Y_W+1:Y_W-1] == 3'b000 || y_wide[Y_W+1:Y_W-1] == 3'b111)
        begin
            y_next = y_wide[Y_W-1:0];
        end
        else if (y_wide[Y_W+1])
        begin
            y_next = $signed({1'b1, {(Y_W-1){1'b0}}});
        end
        else
        begin
            y_next = $signed({1'b0, {(Y_W-1){1'b1}}});
        end
    end

    // Any y outside 32 bits saturates the output for every nonzero gain, so it is
    // clamped before the gain multiply.
    always_comb
    begin
        if (yprev_reg[Y_W-1:MUL_B_W-1] == '0 || yprev_reg[Y_W-1:MUL_B_W-1] == '1)
        begin
            y_clamp = yprev_reg[MUL_B_W-1:0];
        end
        else if (yprev_reg[Y_W-1])
        begin
            y_clamp = $signed({1'b1, {(MUL_B_W-1){1'b0}}});
        end
        else
        begin
            y_clamp = $signed({1'b0, {(MUL_B_W-1){1'b1}}});
        end
    end

    // Truncate the gained value toward zero, saturate, and take its magnitude.
    always_comb
    begin
        p_bias = prod_reg + $signed({{(PROD_W - FRAC_W){1'b0}}, {FRAC_W{prod_reg[PROD_W-1]}}});
        t_int  = p_bias[PROD_W-1:FRAC_W];
        if (t_int[PROD_W-FRAC_W-1:SAMPLE_W-1] == '0 || t_int[PROD_W-FRAC_W-1:SAMPLE_W-1] == '1)
        begin
            s_next = t_int[SAMPLE_W-1:0];
        end
        else if (t_int[PROD_W-FRAC_W-1])
        begin
            s_next = $signed({1'b1, {(SAMPLE_W-1){1'b0}}});
        end
        else
        begin
            s_next = $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
        end
        mag_next = s_next[SAMPLE_W-1] ? (~s_next + 1'b1) : s_next;
    end

    // Frame statistics.
    always_comb
    begin
        sum_next  = sum_reg + SUM_W'(prod_reg[SQ_W-1:0]);
        cnt_next  = cnt_reg + 1'b1;
        peak_next = (mag_reg > peak_reg) ? mag_reg : peak_reg;
        frame_end = last_reg || (cnt_next >= CNT_W'(MAX_FRAME));
    end

    assign out_free = ~out_valid_reg | out_ready;
    assign ds_start = (state_reg == S_ACC) && frame_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_FILT;
            S_FILT:  state_next = S_GAIN;
            S_GAIN:  state_next = S_SAT;
            S_SAT:   state_next = S_SQR;
            S_SQR:   state_next = S_ACC;
            S_ACC:   state_next = frame_end ? S_WAIT : S_OUT;
            S_WAIT:  if (ds_done) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pole_reg      <= POLE_RESET;
            gain_reg      <= GAIN_RESET;
            xprev_reg     <= '0;
            yprev_reg     <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_POLE: pole_reg <= cfg_data[POLE_W-1:0];
                    REG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default:  pole_reg <= pole_reg;
                endcase
            end
            if (state_reg == S_FILT)
            begin
                xprev_reg <= x_reg;
                yprev_reg <= y_next;
            end
            if (state_reg == S_ACC)
            begin
                if (frame_end)
                begin
                    sum_reg  <= '0;
                    peak_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    peak_reg <= peak_next;
                    cnt_reg  <= cnt_next;
                end
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == S_IDLE && in_valid)
        begin
            x_reg    <= sample_in;
            last_reg <= last_in_frame;
        end
        if (state_reg == S_MHI)
        begin
            lo_reg <= prod_reg[Y_W-1:0];
        end
        if (state_reg == S_SAT)
        begin
            s_reg   <= s_next;
            mag_reg <= mag_next;
        end
        if (state_reg == S_ACC)
        begin
            end_reg   <= frame_end;
            fpeak_reg <= peak_next;
        end
        if (state_reg == S_OUT && out_free)
        begin
            sample_out_reg <= s_reg;
            frame_done_reg <= end_reg;
            frame_rms_reg  <= end_reg ? ds_root : '0;
            frame_peak_reg <= end_reg ? fpeak_reg : '0;
        end
    end

    dcbm_divsqrt #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ds_start),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .done     (ds_done),
        .root     (ds_root)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign frame_done = frame_done_reg;
    assign frame_rms  = frame_rms_reg;
    assign frame_peak = frame_peak_reg;

endmodule

// ===== hdl/dcbm_checker.sv =====
// Port-level checks for the DC-blocking filter and level meter, bound to the top level.
// Uses dcbm_pkg for the port types.
module dcbm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input dcbm_pkg::sample_t sample_out,
    input logic              frame_done,
    input dcbm_pkg::level_t  frame_rms,
    input dcbm_pkg::level_t  frame_peak
);
    import dcbm_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(frame_done)
            && $stable(frame_rms) && $stable(frame_peak))
        else $error("stalled output word changed");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word was in progress");

    // Statistics are zero on a word that does not close a frame.
    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> frame_rms == '0 && frame_peak == '0)
        else $error("frame statistics nonzero outside a frame end");

    // The RMS of a frame never exceeds its peak magnitude.
    a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> frame_rms <= frame_peak)
        else $error("frame RMS above frame peak");

endmodule

bind dc_block_gain_rms_peak_meter_top dcbm_checker u_dcbm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .frame_done (frame_done),
    .frame_rms  (frame_rms),
    .frame_peak (frame_peak)
);

// ===== verif/dcbm_meter_checker.sv =====
// Checker for the DC-blocking filter and level meter: it watches the register port and both
// word channels, predicts every output word and compares it field by field.
// Depends on dcbm_pkg.
module dcbm_meter_checker #(
    parameter int MAX_FRAME = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  dcbm_pkg::sample_t               sample_in,
    input  logic                            last_in_frame,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  dcbm_pkg::sample_t               sample_out,
    input  logic                            frame_done,
    input  dcbm_pkg::level_t                frame_rms,
    input  dcbm_pkg::level_t                frame_peak,
    input  logic                            cfg_wr_en,
    input  logic [dcbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              words_in,
    output int                              words_out
);
    timeunit 1ns;
    timeprecision 1ps;

    import dcbm_pkg::*;

    localparam longint Y_HI = 64'sd2199023255551;
    localparam longint Y_LO = -64'sd2199023255552;

    typedef struct packed {
        sample_t smp;
        logic    done;
        level_t  rms;
        level_t  pk;
    } meter_word_t;

    // Copy of the block's registers and state.
    logic [POLE_W-1:0] pole;
    logic [GAIN_W-1:0] gain;
    longint            prev_x;
    longint            y_state;
    longint unsigned   sum_sq;
    longint unsigned   peak_mag;
    longint unsigned   frame_len;

    meter_word_t due_words[$];
    int          n_fail = 0;

    assign fail_count = n_fail;

    function automatic longint unsigned isqrt_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v = v - root - probe;
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Runs one sample through the filter, gain stage and frame statistics.
    function automatic meter_word_t filter_and_meter(sample_t x, logic mark);
        longint          y;
        longint          scaled;
        longint          s;
        longint unsigned mag;
        longint unsigned root;
        meter_word_t     w;
        // The feedback product is floored back to Q25.16 by the arithmetic shift.
        y = (longint'(x) - prev_x) * 65536 + ((longint'(pole) * y_state) >>> 16);
        if (y > Y_HI)
            y = Y_HI;
        if (y < Y_LO)
            y = Y_LO;
        prev_x = longint'(x);
        y_state = y;

        scaled = y * longint'(gain);
        if (scaled < 0)
            s = -((-scaled) >>> 16);
        else
            s = scaled >>> 16;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;

        mag = (s < 0) ? -s : s;
        sum_sq = sum_sq + mag * mag;
        if (mag > peak_mag)
            peak_mag = mag;
        frame_len = frame_len + 1;

        w.smp = s[15:0];
        w.done = 1'b0;
        w.rms = '0;
        w.pk = '0;
        // A frame that reaches MAX_FRAME words closes even without the mark.
        if (mark || frame_len >= MAX_FRAME)
        begin
            root = isqrt_floor(sum_sq / frame_len);
            w.done = 1'b1;
            w.rms = root[15:0];
            w.pk = peak_mag[15:0];
            sum_sq = 0;
            peak_mag = 0;
            frame_len = 0;
        end
        return w;
    endfunction

    task automatic flag(input string field, input longint want, input longint got);
        n_fail++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        meter_word_t w;
        if (!rst_n)
        begin
            pole = POLE_RESET;
            gain = GAIN_RESET;
            prev_x = 0;
            y_state = 0;
            sum_sq = 0;
            peak_mag = 0;
            frame_len = 0;
            due_words.delete();
            words_in <= 0;
            words_out <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_POLE)
                    pole = cfg_data[POLE_W-1:0];
                else if (cfg_index == REG_GAIN)
                    gain = cfg_data[GAIN_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                due_words.push_back(filter_and_meter(sample_in, last_in_frame));
                words_in <= words_in + 1;
            end
            if (out_valid && out_ready)
            begin
                words_out <= words_out + 1;
                if (due_words.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected word, expected none, got sample %0d done %0b",
                             $time, $signed(sample_out), frame_done);
                end
                else
                begin
                    w = due_words.pop_front();
                    if (sample_out !== w.smp)
                        flag("sample_out", $signed(w.smp), $signed(sample_out));
                    if (frame_done !== w.done)
                        flag("frame_done", w.done, frame_done);
                    if (frame_rms !== w.rms)
                        flag("frame_rms", w.rms, frame_rms);
                    if (frame_peak !== w.pk)
                        flag("frame_peak", w.pk, frame_peak);
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the level meter testbench: clock, reset, word and register stimulus, receiver
// stalls, watchdog and verdict. Depends on dcbm_pkg, dcbm_meter_checker and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcbm_pkg::*;

    localparam int MAX_FRAME  = 512;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    sample_t               sample_in;
    logic                  last_in_frame;
    logic                  out_valid;
    logic                  out_ready;
    sample_t               sample_out;
    logic                  frame_done;
    level_t                frame_rms;
    level_t                frame_peak;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int words_in;
    int words_out;
    int tx_words = 0;
    int rx_words = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    dc_block_gain_rms_peak_meter_top #(
        .MAX_FRAME(MAX_FRAME)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .last_in_frame(last_in_frame),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample_out(sample_out),
        .frame_done(frame_done),
        .frame_rms(frame_rms),
        .frame_peak(frame_peak),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    dcbm_meter_checker #(
        .MAX_FRAME(MAX_FRAME)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .last_in_frame(last_in_frame),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample_out(sample_out),
        .frame_done(frame_done),
        .frame_rms(frame_rms),
        .frame_peak(frame_peak),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .words_in(words_in),
        .words_out(words_out)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stalls, stretches without any, and one long hold-off that lets
    // the block fill up and stall its input.
    initial
    begin : receiver
        int pause;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_words == 300)
                pause = 400;
            else if ((rx_words % 96) < 24)
                pause = 0;
            else
                pause = $urandom_range(0, 8);
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            rx_words++;
        end
    end

    task automatic send_word(input int value, input logic mark);
        int gap;
        gap = ((tx_words % 80) < 20) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= value[15:0];
        last_in_frame <= mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tx_words++;
    endtask

    // Waits until every word has come back and the block has had time to finish a frame end.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_in != words_out)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One frame of a random signal shape; a broken frame carries random marks instead.
    task automatic play_frame(input int len, input bit broken);
        int   kind;
        int   level;
        int   span;
        int   v;
        logic mark;
        kind = $urandom_range(0, 4);
        level = $urandom_range(0, 40000) - 20000;
        span = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: v = $urandom_range(0, 65535) - 32768;
                1: v = level + $urandom_range(0, 400) - 200;
                2:
                begin
                    case ($urandom_range(0, 4))
                        0: v = 32767;
                        1: v = -32768;
                        2: v = 0;
                        3: v = -1;
                        default: v = 1;
                    endcase
                end
                3: v = level;
                default: v = ((i / span) % 2 == 1) ? -level : level;
            endcase
            mark = broken ? ($urandom_range(0, 5) == 0) : (i == len - 1);
            send_word(v, mark);
        end
    endtask

    task automatic run_phase(input logic [15:0] pole, input logic [15:0] gain_word,
                             input int items);
        int start_cnt;
        int len;
        settle();
        write_reg(REG_POLE, pole);
        write_reg(REG_GAIN, gain_word);
        start_cnt = tx_words;
        while (tx_words - start_cnt < items)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            play_frame(len, $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        last_in_frame = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_POLE;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: full-scale steps that saturate both ways, a one-word
        // frame, small steps and a DC level that the filter must remove.
        send_word(0, 1'b0);
        send_word(32767, 1'b0);
        send_word(-32768, 1'b0);
        send_word(32767, 1'b0);
        send_word(-32768, 1'b1);
        send_word(-1, 1'b1);
        send_word(1, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(5000, 1'b0);
        send_word(5000, 1'b0);
        send_word(5000, 1'b0);
        send_word(5000, 1'b1);

        // Register extremes first: a gain of zero gives silence, 31 uses all five bits.
        run_phase(16'hFFFF, 16'd16, 8);
        run_phase(16'h0000, 16'd1, 8);
        run_phase(POLE_RESET, 16'd0, 8);
        run_phase(16'($urandom_range(0, 65535)),
                  16'(($urandom_range(0, 2047) << 5) | 31), 8);
        repeat (4)
            run_phase(16'($urandom_range(0, 65535)),
                      16'(($urandom_range(0, 2047) << 5) | $urandom_range(1, 16)), 8);

        // One unmarked run long enough that the block closes the frame at MAX_FRAME words.
        settle();
        write_reg(REG_POLE, POLE_RESET);
        write_reg(REG_GAIN, 16'(GAIN_RESET));
        repeat (MAX_FRAME + 2)
            send_word($urandom_range(0, 65535) - 32768, 1'b0);
        send_word(0, 1'b1);

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
